FILE: design/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// shared constants, types and trig lookup for the vertex projection block
// ----------------------------------------------------------------------------
package vtp_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 200;
   localparam int DEPTH_MIN     = 16;
   localparam int DEPTH_MAX     = 32767;
   localparam int FIFO_DEPTH    = 2;

   localparam logic [2:0] REG_OBJECT_X     = 3'd0;
   localparam logic [2:0] REG_OBJECT_Y     = 3'd1;
   localparam logic [2:0] REG_OBJECT_ANGLE = 3'd2;
   localparam logic [2:0] REG_VIEWER_X     = 3'd3;
   localparam logic [2:0] REG_VIEWER_Y     = 3'd4;
   localparam logic [2:0] REG_VIEW_ANGLE   = 3'd5;
   localparam logic [2:0] REG_CENTER_X     = 3'd6;
   localparam logic [2:0] REG_CENTER_Y     = 3'd7;

   // rotated vertex handed from front to back
   typedef struct packed {
      logic signed [16:0] vx;      // view-space x, fits in 17 bits
      logic signed [16:0] vy;
      logic signed [15:0] pz;
      logic               first;
      logic               last;
   } vtx_type;

   function automatic logic [6:0] quarter_sine(input logic [6:0] r);
      logic [6:0] v;
      case (r)
         7'd0: v = 7'd0;     7'd1: v = 7'd3;     7'd2: v = 7'd6;     7'd3: v = 7'd9;
         7'd4: v = 7'd13;    7'd5: v = 7'd16;    7'd6: v = 7'd19;    7'd7: v = 7'd22;
         7'd8: v = 7'd25;    7'd9: v = 7'd28;    7'd10: v = 7'd31;   7'd11: v = 7'd34;
         7'd12: v = 7'd37;   7'd13: v = 7'd40;   7'd14: v = 7'd43;   7'd15: v = 7'd46;
         7'd16: v = 7'd49;   7'd17: v = 7'd52;   7'd18: v = 7'd55;   7'd19: v = 7'd58;
         7'd20: v = 7'd60;   7'd21: v = 7'd63;   7'd22: v = 7'd66;   7'd23: v = 7'd68;
         7'd24: v = 7'd71;   7'd25: v = 7'd74;   7'd26: v = 7'd76;   7'd27: v = 7'd79;
         7'd28: v = 7'd81;   7'd29: v = 7'd84;   7'd30: v = 7'd86;   7'd31: v = 7'd88;
         7'd32: v = 7'd91;   7'd33: v = 7'd93;   7'd34: v = 7'd95;   7'd35: v = 7'd97;
         7'd36: v = 7'd99;   7'd37: v = 7'd101;  7'd38: v = 7'd103;  7'd39: v = 7'd105;
         7'd40: v = 7'd106;  7'd41: v = 7'd108;  7'd42: v = 7'd110;  7'd43: v = 7'd111;
         7'd44: v = 7'd113;  7'd45: v = 7'd114;  7'd46: v = 7'd116;  7'd47: v = 7'd117;
         7'd48: v = 7'd118;  7'd49: v = 7'd119;  7'd50: v = 7'd121;  7'd51: v = 7'd122;
         7'd52: v = 7'd122;  7'd53: v = 7'd123;  7'd54: v = 7'd124;  7'd55: v = 7'd125;
         7'd56: v = 7'd126;  7'd57: v = 7'd126;  7'd58: v = 7'd127;  7'd59: v = 7'd127;
         7'd60: v = 7'd127;  default: v = 7'd0;
      endcase
      return v;
   endfunction

   // 128 * sin, nine bits signed
   function automatic logic signed [8:0] sine(input logic [7:0] a);
      logic [6:0] r;
      logic [7:0] mag;
      r   = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
      mag = (r >= 7'd61) ? 8'd128 : {1'b0, quarter_sine(r)};
      return a[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

FILE: design/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front
// accepts vertices and runs both rotations on one shared set of four multipliers
// ----------------------------------------------------------------------------
module vtp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_point_x,
   input  logic signed [15:0]   req_point_y,
   input  logic signed [15:0]   req_point_z,
   input  logic                 req_first_point,
   input  logic                 req_last_point,
   input  logic signed [15:0]   object_x,
   input  logic signed [15:0]   object_y,
   input  logic [7:0]           object_angle,
   input  logic signed [15:0]   viewer_x,
   input  logic signed [15:0]   viewer_y,
   input  logic [7:0]           view_angle,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vtp_pkg::vtx_type     out_vtx
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROT1 = 2'd1;
   localparam logic [1:0] ST_ROT2 = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic signed [15:0] a_ff, a_in, b_ff, b_in;
   logic signed [15:0] pz_ff, pz_in;
   logic               first_ff, first_in, last_ff, last_in;
   logic signed [16:0] vx_ff, vx_in, vy_ff, vy_in;

   logic signed [8:0]  cs, sn;
   logic signed [25:0] p0, p1, p2, p3;
   logic signed [26:0] r0, r1;
   logic signed [19:0] s0, s1;
   logic signed [15:0] m0, m1;

   always_comb begin
      if (state_ff == ST_ROT1) begin
         sn = vtp_pkg::sine(object_angle);
         cs = vtp_pkg::sine(object_angle + 8'd64);
      end else begin
         // view rotation has sine and cosine exchanged
         cs = vtp_pkg::sine(view_angle);
         sn = vtp_pkg::sine(view_angle + 8'd64);
      end
      p0 = a_ff * cs;
      p1 = b_ff * sn;
      p2 = a_ff * sn;
      p3 = b_ff * cs;
      r0 = 27'(p0) - 27'(p1);
      r1 = 27'(p2) + 27'(p3);
      s0 = 20'(r0 >>> 7);
      s1 = 20'(r1 >>> 7);
      m0 = 16'(s0[15:0] + object_x) - viewer_x;
      m1 = 16'(s1[15:0] + object_y) - viewer_y;
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; pz_in = pz_ff;
      first_in = first_ff; last_in = last_ff;
      vx_in = vx_ff; vy_in = vy_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = req_point_x; b_in = req_point_y; pz_in = req_point_z;
               first_in = req_first_point; last_in = req_last_point;
               state_in = ST_ROT1;
            end
         end
         ST_ROT1: begin
            a_in = m0; b_in = m1;
            state_in = ST_ROT2;
         end
         ST_ROT2: begin
            vx_in = s0[16:0]; vy_in = s1[16:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      a_ff <= a_in; b_ff <= b_in; pz_ff <= pz_in;
      first_ff <= first_in; last_ff <= last_in;
      vx_ff <= vx_in; vy_ff <= vy_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign out_vtx   = '{vx: vx_ff, vy: vy_ff, pz: pz_ff, first: first_ff, last: last_ff};

endmodule

FILE: design/vtp_fifo.sv
// ----------------------------------------------------------------------------
// vtp_fifo
// short queue of rotated vertices between front and back
// ----------------------------------------------------------------------------
module vtp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vtp_pkg::vtx_type  in_vtx,
   output logic              out_valid,
   input  logic              out_ready,
   output vtp_pkg::vtx_type  out_vtx
);

   localparam int AW = $clog2(vtp_pkg::FIFO_DEPTH);

   vtp_pkg::vtx_type   mem_ff [vtp_pkg::FIFO_DEPTH];
   logic [AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(vtp_pkg::FIFO_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_vtx   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? AW'((wr_ff + 1'b1) % vtp_pkg::FIFO_DEPTH) : wr_ff;
      rd_in  = pop  ? AW'((rd_ff + 1'b1) % vtp_pkg::FIFO_DEPTH) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_vtx;
   end

endmodule

FILE: design/vtp_back.sv
// ----------------------------------------------------------------------------
// vtp_back
// serial division by depth for both screen axes, then bounds tracking
// ----------------------------------------------------------------------------
module vtp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vtp_pkg::vtx_type   in_vtx,
   input  logic [9:0]         center_x,
   input  logic [9:0]         center_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_z,
   output logic [14:0]        rsp_view_depth,
   output logic signed [15:0] rsp_box_x_min,
   output logic signed [15:0] rsp_box_x_max,
   output logic signed [15:0] rsp_box_z_min,
   output logic signed [15:0] rsp_box_z_max,
   output logic [14:0]        rsp_nearest_depth,
   output logic               rsp_visible,
   output logic               rsp_last_flag
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIVX  = 3'd1;
   localparam logic [2:0] ST_DIVZ  = 3'd2;
   localparam logic [2:0] ST_TRACK = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam int QW = 25;   // |numerator| < 2^25

   logic [2:0]         state_ff, state_in;
   logic [4:0]         bit_ff, bit_in;
   logic [16:0]        den_ff, den_in;
   logic [QW-1:0]      num_ff, num_in, quo_ff, quo_in;
   logic [17:0]        rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] sx_ff, sx_in, sz_ff, sz_in, pz_ff, pz_in;
   logic [14:0]        dsat_ff, dsat_in;
   logic               first_ff, first_in, last_ff, last_in;
   logic signed [15:0] xl_ff, xl_in, xh_ff, xh_in, zl_ff, zl_in, zh_ff, zh_in;
   logic [14:0]        nr_ff, nr_in;

   logic [16:0]        d_c;
   logic [QW-1:0]      nx_abs, nz_abs;
   logic signed [QW:0] nx_s, nz_s;
   logic [17:0]        trial;
   logic [QW-1:0]      qfin;
   logic signed [15:0] qs;
   logic               vis;

   always_comb begin
      d_c  = (in_vtx.vy <= 17'(vtp_pkg::DEPTH_MIN)) ? 17'(vtp_pkg::DEPTH_MIN)
                                                    : 17'(in_vtx.vy);
      nx_s = (QW+1)'(in_vtx.vx) <<< 8;
      nz_s = (QW+1)'(pz_ff) <<< 8;
      nx_abs = nx_s[QW] ? QW'(-nx_s) : QW'(nx_s);
      nz_abs = nz_s[QW] ? QW'(-nz_s) : QW'(nz_s);
      trial = {rem_ff[16:0], num_ff[QW-1]} - {1'b0, den_ff};
      qfin  = {quo_ff[QW-2:0], ~trial[17]};
      qs    = neg_ff ? -16'(qfin) : 16'(qfin);
      vis   = !(xh_ff[15] || (xl_ff > 16'(vtp_pkg::SCREEN_WIDTH)) ||
                (zl_ff > 16'(vtp_pkg::SCREEN_HEIGHT)));
   end

   always_comb begin
      state_in = state_ff; bit_in = bit_ff; den_in = den_ff;
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      sx_in = sx_ff; sz_in = sz_ff; pz_in = pz_ff; dsat_in = dsat_ff;
      first_in = first_ff; last_in = last_ff;
      xl_in = xl_ff; xh_in = xh_ff; zl_in = zl_ff; zh_in = zh_ff; nr_in = nr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               den_in = d_c;
               dsat_in = d_c[16] ? 15'(vtp_pkg::DEPTH_MAX) : d_c[14:0];
               if (d_c[15]) dsat_in = 15'(vtp_pkg::DEPTH_MAX);
               pz_in = in_vtx.pz;
               first_in = in_vtx.first; last_in = in_vtx.last;
               num_in = nx_abs; neg_in = in_vtx.vx[16];
               quo_in = '0; rem_in = '0; bit_in = 5'(QW - 1);
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVZ: begin
            // one restoring step a cycle
            rem_in = trial[17] ? {rem_ff[16:0], num_ff[QW-1]} : trial;
            num_in = num_ff << 1;
            quo_in = qfin;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == '0) begin
               if (state_ff == ST_DIVX) begin
                  sx_in = 16'({6'd0, center_x}) + qs;
                  num_in = nz_abs; neg_in = pz_ff[15];
                  quo_in = '0; rem_in = '0; bit_in = 5'(QW - 1);
                  state_in = ST_DIVZ;
               end else begin
                  sz_in = 16'({6'd0, center_y}) - qs;
                  state_in = ST_TRACK;
               end
            end
         end
         ST_TRACK: begin
            if (first_ff) begin
               xl_in = sx_ff; xh_in = sx_ff; zl_in = sz_ff; zh_in = sz_ff;
               nr_in = dsat_ff;
            end else begin
               if (sx_ff < xl_ff) xl_in = sx_ff;
               if (sx_ff > xh_ff) xh_in = sx_ff;
               if (sz_ff < zl_ff) zl_in = sz_ff;
               if (sz_ff > zh_ff) zh_in = sz_ff;
               if (dsat_ff < nr_ff) nr_in = dsat_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         xl_ff <= '0; xh_ff <= '0; zl_ff <= '0; zh_ff <= '0;
         nr_ff <= 15'(vtp_pkg::DEPTH_MAX);
      end else begin
         state_ff <= state_in;
         xl_ff <= xl_in; xh_ff <= xh_in; zl_ff <= zl_in; zh_ff <= zh_in;
         nr_ff <= nr_in;
      end
      bit_ff <= bit_in; den_ff <= den_in; num_ff <= num_in; quo_ff <= quo_in;
      rem_ff <= rem_in; neg_ff <= neg_in; sx_ff <= sx_in; sz_ff <= sz_in;
      pz_ff <= pz_in; dsat_ff <= dsat_in; first_ff <= first_in; last_ff <= last_in;
   end

   assign in_ready          = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_screen_x      = sx_ff;
   assign rsp_screen_z      = sz_ff;
   assign rsp_view_depth    = dsat_ff;
   assign rsp_box_x_min     = xl_ff;
   assign rsp_box_x_max     = xh_ff;
   assign rsp_box_z_min     = zl_ff;
   assign rsp_box_z_max     = zh_ff;
   assign rsp_nearest_depth = nr_ff;
   assign rsp_visible       = last_ff && vis;
   assign rsp_last_flag     = last_ff;

endmodule

FILE: design/vertex_transform_project.sv
// ----------------------------------------------------------------------------
// vertex_transform_project
// rotates, translates and projects object vertices, tracking per-object bounds
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  point xyz, first/last flags
//  rsp       out        rsp_valid/rsp_ready  screen xz, depth, box, visible
//  csr       in         csr_write            csr_index, csr_data
//
//  front: one vertex at a time, two rotations in turn on a shared multiplier set
//  back: one vertex at a time, serial divider by depth (25 steps per axis)
//  a two-entry queue lets the front run ahead while the back divides
//  reset is synchronous; box tracks clear to zero, nearest depth to 32767
module vertex_transform_project (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic               req_first_point,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_z,
   output logic [14:0]        rsp_view_depth,
   output logic signed [15:0] rsp_box_x_min,
   output logic signed [15:0] rsp_box_x_max,
   output logic signed [15:0] rsp_box_z_min,
   output logic signed [15:0] rsp_box_z_max,
   output logic [14:0]        rsp_nearest_depth,
   output logic               rsp_visible,
   output logic               rsp_last_flag,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   logic signed [15:0] obj_x_ff, obj_y_ff, view_x_ff, view_y_ff;
   logic [7:0]         obj_ang_ff, view_ang_ff;
   logic [9:0]         ctr_x_ff, ctr_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_x_ff <= '0; obj_y_ff <= '0; obj_ang_ff <= '0;
         view_x_ff <= '0; view_y_ff <= '0; view_ang_ff <= '0;
         ctr_x_ff <= 10'd160; ctr_y_ff <= 10'd100;
      end else if (csr_write) begin
         unique case (csr_index)
            vtp_pkg::REG_OBJECT_X:     obj_x_ff    <= csr_data;
            vtp_pkg::REG_OBJECT_Y:     obj_y_ff    <= csr_data;
            vtp_pkg::REG_OBJECT_ANGLE: obj_ang_ff  <= csr_data[7:0];
            vtp_pkg::REG_VIEWER_X:     view_x_ff   <= csr_data;
            vtp_pkg::REG_VIEWER_Y:     view_y_ff   <= csr_data;
            vtp_pkg::REG_VIEW_ANGLE:   view_ang_ff <= csr_data[7:0];
            vtp_pkg::REG_CENTER_X:     ctr_x_ff    <= csr_data[9:0];
            vtp_pkg::REG_CENTER_Y:     ctr_y_ff    <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   logic             f_valid, f_ready, q_valid, q_ready;
   vtp_pkg::vtx_type f_vtx, q_vtx;

   vtp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_point_x, .req_point_y,
      .req_point_z, .req_first_point, .req_last_point,
      .object_x(obj_x_ff), .object_y(obj_y_ff), .object_angle(obj_ang_ff),
      .viewer_x(view_x_ff), .viewer_y(view_y_ff), .view_angle(view_ang_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_vtx(f_vtx)
   );

   vtp_fifo u_fifo (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_vtx(f_vtx),
      .out_valid(q_valid), .out_ready(q_ready), .out_vtx(q_vtx)
   );

   vtp_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_vtx(q_vtx),
      .center_x(ctr_x_ff), .center_y(ctr_y_ff),
      .rsp_valid, .rsp_ready, .rsp_screen_x, .rsp_screen_z, .rsp_view_depth,
      .rsp_box_x_min, .rsp_box_x_max, .rsp_box_z_min, .rsp_box_z_max,
      .rsp_nearest_depth, .rsp_visible, .rsp_last_flag
   );

   // visibility only on the final vertex
   a_vis_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_last_flag)
      else $error("visible without last flag");

   a_depth_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_view_depth >= 15'd16)
      else $error("depth below clamp");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x))
      else $error("result dropped while stalled");

endmodule

FILE: verif/vertex_transform_project_checker.sv
// ----------------------------------------------------------------------------
// vertex_transform_project_checker
// watches the request and response channels, predicts each response from the
// accepted request and the current register values, and counts mismatches
// ----------------------------------------------------------------------------
module vertex_transform_project_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic               req_first_point,
   input  logic               req_last_point,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_screen_x,
   input  logic signed [15:0] rsp_screen_z,
   input  logic [14:0]        rsp_view_depth,
   input  logic signed [15:0] rsp_box_x_min,
   input  logic signed [15:0] rsp_box_x_max,
   input  logic signed [15:0] rsp_box_z_min,
   input  logic signed [15:0] rsp_box_z_max,
   input  logic [14:0]        rsp_nearest_depth,
   input  logic               rsp_visible,
   input  logic               rsp_last_flag,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sz;
      logic [14:0]        depth;
      logic signed [15:0] xmin;
      logic signed [15:0] xmax;
      logic signed [15:0] zmin;
      logic signed [15:0] zmax;
      logic [14:0]        near;
      logic               vis;
      logic               last;
   } projection_type;

   projection_type projections_due[$];

   logic signed [15:0] obj_x, obj_y, view_x, view_y;
   logic [7:0]         obj_ang, view_ang;
   logic [9:0]         ctr_x, ctr_y;
   longint             x_lo, x_hi, z_lo, z_hi, near_lo;
   int                 sin_lut[256];

   initial begin
      int q, r, v;
      int quarter[65] = '{0, 3, 6, 9, 13, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
         49, 52, 55, 58, 60, 63, 66, 68, 71, 74, 76, 79, 81, 84, 86, 88, 91, 93, 95,
         97, 99, 101, 103, 105, 106, 108, 110, 111, 113, 114, 116, 117, 118, 119, 121,
         122, 122, 123, 124, 125, 126, 126, 127, 127, 127, 128, 128, 128, 128};
      for (int i = 0; i < 256; i++) begin
         q = i >> 6;
         r = i & 63;
         v = (q & 1) ? quarter[64 - r] : quarter[r];
         sin_lut[i] = (q & 2) ? -v : v;
      end
   end

   function automatic longint wrap16(longint v);
      return longint'(signed'(v[15:0]));
   endfunction

   // >>> on a signed longint is a floor shift
   function automatic longint shr7(longint v);
      return v >>> 7;
   endfunction

   function automatic projection_type project_vertex(longint px, longint py, longint pz,
                                                      logic first, logic last);
      projection_type p;
      longint oc, os, vc, vs, mx, my, x, y, vx, vy, d, dsat, sx, sz;
      logic vis;
      oc = sin_lut[(obj_ang + 64) & 255];
      os = sin_lut[obj_ang];
      vc = sin_lut[(view_ang + 64) & 255];
      vs = sin_lut[view_ang];
      mx = wrap16(wrap16(shr7(px * oc - py * os)) + longint'(obj_x));
      my = wrap16(wrap16(shr7(px * os + py * oc)) + longint'(obj_y));
      x = wrap16(mx - longint'(view_x));
      y = wrap16(my - longint'(view_y));
      vx = shr7(x * vs - y * vc);
      vy = shr7(x * vc + y * vs);
      d = (vy <= vtp_pkg::DEPTH_MIN) ? vtp_pkg::DEPTH_MIN : vy;
      dsat = (d > vtp_pkg::DEPTH_MAX) ? vtp_pkg::DEPTH_MAX : d;
      sx = wrap16(longint'(ctr_x) + (vx * 256) / d);
      sz = wrap16(longint'(ctr_y) - (pz * 256) / d);
      if (first) begin
         x_lo = sx; x_hi = sx; z_lo = sz; z_hi = sz; near_lo = dsat;
      end else begin
         if (sx < x_lo) x_lo = sx;
         if (sx > x_hi) x_hi = sx;
         if (sz < z_lo) z_lo = sz;
         if (sz > z_hi) z_hi = sz;
         if (dsat < near_lo) near_lo = dsat;
      end
      vis = !(x_hi < 0 || x_lo > vtp_pkg::SCREEN_WIDTH || z_lo > vtp_pkg::SCREEN_HEIGHT);
      p.sx = sx[15:0];
      p.sz = sz[15:0];
      p.depth = dsat[14:0];
      p.xmin = x_lo[15:0];
      p.xmax = x_hi[15:0];
      p.zmin = z_lo[15:0];
      p.zmax = z_hi[15:0];
      p.near = near_lo[14:0];
      p.vis = last && vis;
      p.last = last;
      return p;
   endfunction

   always @(posedge clock) begin
      projection_type want, got;
      if (reset) begin
         obj_x <= '0; obj_y <= '0; obj_ang <= '0;
         view_x <= '0; view_y <= '0; view_ang <= '0;
         ctr_x <= 10'd160; ctr_y <= 10'd100;
         x_lo = 0; x_hi = 0; z_lo = 0; z_hi = 0; near_lo = vtp_pkg::DEPTH_MAX;
         projections_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               vtp_pkg::REG_OBJECT_X:     obj_x <= csr_data;
               vtp_pkg::REG_OBJECT_Y:     obj_y <= csr_data;
               vtp_pkg::REG_OBJECT_ANGLE: obj_ang <= csr_data[7:0];
               vtp_pkg::REG_VIEWER_X:     view_x <= csr_data;
               vtp_pkg::REG_VIEWER_Y:     view_y <= csr_data;
               vtp_pkg::REG_VIEW_ANGLE:   view_ang <= csr_data[7:0];
               vtp_pkg::REG_CENTER_X:     ctr_x <= csr_data[9:0];
               vtp_pkg::REG_CENTER_Y:     ctr_y <= csr_data[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            projections_due.push_back(project_vertex(req_point_x, req_point_y,
               req_point_z, req_first_point, req_last_point));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_screen_x, rsp_screen_z, rsp_view_depth, rsp_box_x_min,
                    rsp_box_x_max, rsp_box_z_min, rsp_box_z_max, rsp_nearest_depth,
                    rsp_visible, rsp_last_flag};
            if (projections_due.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = projections_due.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch expected sx=%0d sz=%0d d=%0d box=%0d..%0d,%0d..%0d near=%0d vis=%0d last=%0d",
                     $time, want.sx, want.sz, want.depth, want.xmin, want.xmax,
                     want.zmin, want.zmax, want.near, want.vis, want.last);
                  $display("%0t:          actual sx=%0d sz=%0d d=%0d box=%0d..%0d,%0d..%0d near=%0d vis=%0d last=%0d",
                     $time, got.sx, got.sz, got.depth, got.xmin, got.xmax,
                     got.zmin, got.zmax, got.near, got.vis, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= projections_due.size();
   end

endmodule

FILE: verif/vertex_transform_project_test.sv
// ----------------------------------------------------------------------------
// vertex_transform_project_test
// drives vertex requests and register settings into the projection block
// under varied back-pressure; the checker predicts and compares responses
// ----------------------------------------------------------------------------
module vertex_transform_project_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic signed [15:0] req_point_z = '0;
   logic               req_first_point = 1'b0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_screen_x, rsp_screen_z;
   logic [14:0]        rsp_view_depth, rsp_nearest_depth;
   logic signed [15:0] rsp_box_x_min, rsp_box_x_max, rsp_box_z_min, rsp_box_z_max;
   logic               rsp_visible, rsp_last_flag;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   int                 fail_count, pending;
   int                 send_idle_pct = 0, recv_idle_pct = 0;
   bit                 hold_off = 1'b0;
   int                 quiet_cycles = 0;

   localparam int QUIET_LIMIT = 20000;

   always #5 clock = ~clock;

   vertex_transform_project dut (.*);

   vertex_transform_project_checker checker_i (.*);

   always @(posedge clock) begin
      if (hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("vertex_transform_project_test NOT OK");
         $finish;
      end
   end

   // valid stays high between back-to-back requests; drain drops it
   task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic first, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_first_point <= first;
      req_last_point <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(400)) - 200);
         2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   task automatic random_settings(bit extreme);
      write_reg(vtp_pkg::REG_OBJECT_X, extreme ? 16'h7fff : rand_coord());
      write_reg(vtp_pkg::REG_OBJECT_Y, extreme ? 16'h8000 : rand_coord());
      write_reg(vtp_pkg::REG_OBJECT_ANGLE, extreme ? 16'hff : 16'($urandom_range(255)));
      write_reg(vtp_pkg::REG_VIEWER_X, extreme ? 16'h8000 : rand_coord());
      write_reg(vtp_pkg::REG_VIEWER_Y, extreme ? 16'h7fff : rand_coord());
      write_reg(vtp_pkg::REG_VIEW_ANGLE, extreme ? 16'hff : 16'($urandom_range(255)));
      write_reg(vtp_pkg::REG_CENTER_X, extreme ? 16'h3ff : 16'($urandom_range(1023)));
      write_reg(vtp_pkg::REG_CENTER_Y, extreme ? 16'h0 : 16'($urandom_range(1023)));
   endtask

   task automatic random_objects(int count);
      int n;
      while (count > 0) begin
         n = $urandom_range(8, 1);
         for (int i = 0; i < n && count > 0; i++) begin
            // mostly well-formed objects, some broken flag sequences
            if ($urandom_range(9) == 0)
               send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom),
                           1'($urandom));
            else
               send_vertex(rand_coord(), rand_coord(), rand_coord(), i == 0, i == n - 1);
            count--;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // points before any first point merge with the reset tracks
      send_vertex(16'sd100, 16'sd200, 16'sd10, 1'b0, 1'b0);
      send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
      send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
      send_vertex(16'h0, 16'h0, 16'h0, 1'b0, 1'b1);
      send_vertex(16'hffff, 16'h1, 16'h7fff, 1'b1, 1'b1);
      drain();
      // facing along y so depth follows the y coordinate, then reaches 32767
      write_reg(vtp_pkg::REG_VIEW_ANGLE, 16'd64);
      send_vertex(16'h7fff, 16'h0, 16'sd500, 1'b1, 1'b0);
      drain();
      write_reg(vtp_pkg::REG_OBJECT_X, 16'h7fff);
      send_vertex(16'h7fff, 16'h7fff, 16'h8000, 1'b0, 1'b1);
      drain();
      write_reg(vtp_pkg::REG_VIEWER_X, 16'h8000);
      send_vertex(16'h7fff, 16'h0, 16'sd1, 1'b1, 1'b1);
      drain();
      random_settings(1'b1);
      send_vertex(16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0);
      send_vertex(16'h8000, 16'h7fff, 16'h0, 1'b0, 1'b1);
      drain();
      // an oversized center value keeps only its low ten bits (all eight indices used, none spare)
      write_reg(vtp_pkg::REG_CENTER_X, 16'hffff);
      send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 17 : 0;
         for (int k = 0; k < 4; k++) begin
            if (phase == 0 && k == 0) begin
               write_reg(vtp_pkg::REG_OBJECT_ANGLE, 16'h0);
               write_reg(vtp_pkg::REG_VIEW_ANGLE, 16'h0);
               write_reg(vtp_pkg::REG_CENTER_X, 16'h0);
            end else
               random_settings(1'b0);
            if (k == 1) begin
               // long receiver stall while requests keep coming
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (1500) @(posedge clock);
                     hold_off = 1'b0;
                  end
                  random_objects(12);
               join
            end
            random_objects(125);
            // sender waits for every outstanding response
            drain();
         end
      end

      drain();
      if (fail_count == 0)
         $display("vertex_transform_project_test OK");
      else
         $display("vertex_transform_project_test NOT OK");
      $finish;
   end

endmodule
